// ===== src/cist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cist_pkg
// Shared types and constants for the compact id set table.
// ----------------------------------------------------------------------------
package cist_pkg;

  localparam int ID_W    = 32;
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int IN_W    = 40;  // func + id, padded to bytes
  localparam int OUT_W   = 16;  // found + position + count + full_reject, padded

  localparam logic [ID_W-1:0] EMPTY_ID = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_UPD
  } state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic            cmp_en;
    logic            ins_en;
    logic            rem_en;
    logic [ID_W-1:0] id;
  } cell_cmd_t;

endpackage

// ===== src/compact_id_set_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_id_set_table
// Ordered, densely packed set of unique ids with lookup, insert and remove.
// ----------------------------------------------------------------------------
// Sequence: each item walks compare, reduce and update; the result is registered
//   on leaving update, which waits while the output register is occupied.
// Flow: one item at a time; a new item is accepted only in idle, after the last
//   has walked the compare / reduce / update sequence through the cell chain.
// Reset: synchronous; count goes to zero and every cell to the empty id at
//   once, no clearing pass.
module compact_id_set_table import cist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  // input items
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [1:0] func, [33:2] id, [39:34] zero
  // result items
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [0] found, [6:1] position, [13:7] count,
                                      // [14] full_reject, [15] zero
);

  localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int PWIDE   = (SLOT_W > POS_W) ? SLOT_W : POS_W;
  localparam int CWIDE   = (CW > CNT_W) ? CW : CNT_W;

  // --------------------------------------------------------------------------
  // Control and operation registers
  // --------------------------------------------------------------------------
  state_t            state, state_next;
  logic [FUNC_W-1:0] op_func;
  logic [ID_W-1:0]   op_id;
  logic              hit_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CW-1:0]     count;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  cell_cmd_t         cmd;
  logic [SLOT_W-1:0] upd_slot;
  logic [ID_W-1:0]   entries [CAPACITY];
  logic [CAPACITY-1:0] match;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_W-1:0] nb;
    if (g == CAPACITY - 1) begin : g_top
      assign nb = EMPTY_ID;  // top slot refills with empty on a shift
    end else begin : g_mid
      assign nb = entries[g+1];
    end
    cist_cell #(
      .IDX    (g),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .slot     (upd_slot),
      .nb_entry (nb),
      .entry    (entries[g]),
      .match    (match[g])
    );
  end

  logic              red_hit;
  logic [SLOT_W-1:0] red_slot;

  cist_reduce #(
    .CAPACITY (CAPACITY),
    .SLOT_W   (SLOT_W)
  ) u_reduce (
    .match (match),
    .hit   (red_hit),
    .slot  (red_slot)
  );

  // --------------------------------------------------------------------------
  // Update decision (meaningful in ST_UPD)
  // --------------------------------------------------------------------------
  logic out_free;
  logic is_ins, is_rem, reserved, has_room;
  logic do_ins, do_rem, reject;
  logic [SLOT_W-1:0] pos;
  logic [PWIDE-1:0]  pos_wide;
  logic [CW-1:0]     count_next;
  logic [CWIDE-1:0]  cnt_wide;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    is_ins   = (op_func == FUNC_INSERT);
    is_rem   = (op_func == FUNC_REMOVE);   // code 3 falls through to lookup
    reserved = (op_id == EMPTY_ID);
    has_room = (count < CW'(CAPACITY));
    do_ins   = is_ins && !hit_r && !reserved && has_room;
    reject   = is_ins && !hit_r && !reserved && !has_room;
    do_rem   = is_rem && hit_r;
    if (hit_r) begin
      pos = slot_r;
    end else if (do_ins) begin
      pos = count[SLOT_W-1:0];
    end else begin
      pos = '0;
    end
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_rem) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
    upd_slot = do_ins ? count[SLOT_W-1:0] : slot_r;
    pos_wide = PWIDE'(pos);
    cnt_wide = CWIDE'(count_next);
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_RED;
      ST_RED:  state_next = ST_UPD;
      ST_UPD:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd.cmp_en = 1'b0;
    cmd.ins_en = 1'b0;
    cmd.rem_en = 1'b0;
    cmd.id     = op_id;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_CMP:  cmd.cmp_en = 1'b1;
      ST_RED:  ;
      ST_UPD: begin
        cmd.ins_en = out_free && do_ins;
        cmd.rem_en = out_free && do_rem;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPD && out_free) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_func <= s_tdata[FUNC_W-1:0];
      op_id   <= s_tdata[FUNC_W +: ID_W];
    end
    if (state == ST_RED) begin
      hit_r  <= red_hit;
      slot_r <= red_slot;
    end
    if (state == ST_UPD && out_free) begin
      m_tdata <= {1'b0, reject, cnt_wide[CNT_W-1:0], pos_wide[POS_W-1:0], hit_r};
    end
  end

endmodule

// ===== src/cist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cist_cell
// One slot of the table: holds an id, compares it, loads or shifts down.
// ----------------------------------------------------------------------------
module cist_cell import cist_pkg::*; #(
  parameter int IDX    = 0,
  parameter int SLOT_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic [SLOT_W-1:0] slot,
  input  logic [ID_W-1:0]   nb_entry,  // entry of the next cell up
  output logic [ID_W-1:0]   entry,
  output logic              match
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= EMPTY_ID;
      match <= 1'b0;
    end else begin
      if (cmd.cmp_en) begin
        match <= (entry == cmd.id) && (cmd.id != EMPTY_ID);
      end
      if (cmd.ins_en && (slot == MY_IDX)) begin
        entry <= cmd.id;
      end else if (cmd.rem_en && (MY_IDX >= slot)) begin
        entry <= nb_entry;
      end
    end
  end

endmodule

// ===== src/cist_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cist_reduce
// Folds the per-cell match flags into a hit flag and a slot number.
// ----------------------------------------------------------------------------
module cist_reduce #(
  parameter int CAPACITY = 64,
  parameter int SLOT_W   = 6
) (
  input  logic [CAPACITY-1:0] match,
  output logic                hit,
  output logic [SLOT_W-1:0]   slot
);

  // ids are unique, so at most one flag is set: an OR of indices is enough
  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        slot = slot | SLOT_W'(i);
      end
    end
    hit = |match;
  end

endmodule
